>>> hw/rtl/rps_pkg.sv
// Package for the repeating pulse sequencer: word types, command and mode codes,
// controller state encoding and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package rps_pkg;

  // Table depth default, handed down from the top level
  localparam int MAX_ENTRIES_DEF = 16;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int ITF_W   = 3;
  localparam int PIN_W   = 8;
  localparam int CHAN_W  = 4;

  // At most this many result words per input word
  localparam int RESULT_CAP = 32;
  localparam int EMIT_CW    = $clog2(RESULT_CAP + 1);

  // Interface code that marks a load as invalid
  localparam logic [ITF_W-1:0] ITF_INVALID = 3'd7;

  // Result kinds
  localparam logic KIND_LEVEL  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_START    = 3'd2,
    CMD_PAUSE    = 3'd3,
    CMD_CONTINUE = 3'd4,
    CMD_STOP     = 3'd5,
    CMD_ABORT    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ST_RD,
    S_ST_EMIT,
    S_ST_END,
    S_EV_RD,
    S_EV_CHK,
    S_EV_END,
    S_STOP,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [ITF_W-1:0]  target_interface;
    logic [PIN_W-1:0]  pin_number;
    logic [TIME_W-1:0] on_offset;
    logic [TIME_W-1:0] on_duration;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] channel;
    logic [ITF_W-1:0]  out_interface;
    logic [PIN_W-1:0]  out_pin;
    logic              level;
    logic              last;
  } out_word_t;

  // One table entry as stored in RAM
  typedef struct packed {
    logic [ITF_W-1:0]  itf;
    logic [PIN_W-1:0]  pin;
    logic [TIME_W-1:0] offset;
    logic [TIME_W-1:0] duration;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture input word
    logic load;      // append entry
    logic tick_gap;  // count down the gap
    logic tick_adv;  // advance elapsed, start a walk
    logic restart;   // new cycle at elapsed 0
    logic pause;
    logic report;    // stopped report, empty table
    logic abort;     // empty table
    logic idx_clr;
    logic rd_en;
    logic st_emit;   // drive entry low
    logic ev_commit; // apply one entry's evaluation
    logic ev_end;    // close a walk
    logic flush;     // release last pending word
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_e mode;
    cmd_e  cmd;
    logic  load_ok;
    logic  in_gap;
    logic  gap_restart;
    logic  idx_end;
    logic  ev_change;
    logic  emit_go;
    logic  pend_valid;
    logic  out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/rps_if.sv
// Channel interfaces of the repeating pulse sequencer: input, result and config.
// Depends on rps_pkg for the word types.
`default_nettype none

interface rps_in_if;
  logic             valid;
  logic             ready;
  rps_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rps_out_if;
  logic               valid;
  logic               ready;
  rps_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rps_pkg::TIME_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/rps_ctrl.sv
// Controller of the repeating pulse sequencer: decodes each input word and
// sequences table walks. Depends on rps_pkg.
`default_nettype none

module rps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  output      rps_pkg::ctrl_cmd_t cmd,
  input  wire rps_pkg::ctrl_sts_t sts
);

  rps_pkg::state_e state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rps_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rps_pkg::S_DECODE;
      end
      rps_pkg::S_DECODE: begin
        state_nxt = rps_pkg::S_FINISH;
        unique case (sts.cmd)
          rps_pkg::CMD_TICK: begin
            if (sts.mode == rps_pkg::MODE_RUN &&
                (!sts.in_gap || sts.gap_restart)) begin
              state_nxt = rps_pkg::S_EV_RD;
            end
          end
          rps_pkg::CMD_START: begin
            if (sts.mode == rps_pkg::MODE_IDLE) state_nxt = rps_pkg::S_ST_RD;
          end
          rps_pkg::CMD_CONTINUE: begin
            if (sts.mode == rps_pkg::MODE_PAUSE) state_nxt = rps_pkg::S_EV_RD;
          end
          rps_pkg::CMD_STOP: begin
            if (sts.mode != rps_pkg::MODE_PAUSE) state_nxt = rps_pkg::S_STOP;
          end
          default: state_nxt = rps_pkg::S_FINISH;
        endcase
      end
      rps_pkg::S_ST_RD: begin
        state_nxt = sts.idx_end ? rps_pkg::S_ST_END : rps_pkg::S_ST_EMIT;
      end
      rps_pkg::S_ST_EMIT: begin
        if (sts.emit_go) state_nxt = rps_pkg::S_ST_RD;
      end
      rps_pkg::S_ST_END: state_nxt = rps_pkg::S_EV_RD;
      rps_pkg::S_EV_RD: begin
        state_nxt = sts.idx_end ? rps_pkg::S_EV_END : rps_pkg::S_EV_CHK;
      end
      rps_pkg::S_EV_CHK: begin
        if (!sts.ev_change || sts.emit_go) state_nxt = rps_pkg::S_EV_RD;
      end
      rps_pkg::S_EV_END: state_nxt = rps_pkg::S_FINISH;
      rps_pkg::S_STOP: begin
        if (sts.emit_go) state_nxt = rps_pkg::S_FINISH;
      end
      rps_pkg::S_FINISH: begin
        if (!sts.pend_valid || sts.out_free) state_nxt = rps_pkg::S_IDLE;
      end
      default: state_nxt = rps_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      rps_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      rps_pkg::S_DECODE: begin
        unique case (sts.cmd)
          rps_pkg::CMD_TICK: begin
            if (sts.mode == rps_pkg::MODE_RUN) begin
              if (!sts.in_gap)          cmd.tick_adv = 1'b1;
              else if (sts.gap_restart) cmd.restart  = 1'b1;
              else                      cmd.tick_gap = 1'b1;
            end
          end
          rps_pkg::CMD_LOAD:     cmd.load    = sts.load_ok;
          rps_pkg::CMD_START:    cmd.idx_clr = (sts.mode == rps_pkg::MODE_IDLE);
          rps_pkg::CMD_PAUSE:    cmd.pause   = (sts.mode == rps_pkg::MODE_RUN);
          rps_pkg::CMD_CONTINUE: cmd.restart = (sts.mode == rps_pkg::MODE_PAUSE);
          rps_pkg::CMD_ABORT:    cmd.abort   = 1'b1;
          default: ;
        endcase
      end
      rps_pkg::S_ST_RD:   cmd.rd_en     = !sts.idx_end;
      rps_pkg::S_ST_EMIT: cmd.st_emit   = sts.emit_go;
      rps_pkg::S_ST_END:  cmd.restart   = 1'b1;
      rps_pkg::S_EV_RD:   cmd.rd_en     = !sts.idx_end;
      rps_pkg::S_EV_CHK:  cmd.ev_commit = !sts.ev_change || sts.emit_go;
      rps_pkg::S_EV_END:  cmd.ev_end    = 1'b1;
      rps_pkg::S_STOP:    cmd.report    = sts.emit_go;
      rps_pkg::S_FINISH:  cmd.flush     = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/rps_datapath.sv
// Datapath of the repeating pulse sequencer: entry table RAM, timing state,
// flag vectors, one-word lookahead and output register. Depends on rps_pkg, rps_ram.
`default_nettype none

module rps_datapath #(
  parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rps_pkg::ctrl_cmd_t         cmd,
  output      rps_pkg::ctrl_sts_t         sts,
  input  wire rps_pkg::in_word_t          in_data,
  input  wire logic                       cfg_we,
  input  wire logic [rps_pkg::TIME_W-1:0] cfg_data,
  output      rps_pkg::out_word_t         out_data,
  output      logic                       out_valid,
  input  wire logic                       out_ready
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TW = rps_pkg::TIME_W;
  localparam int EW = rps_pkg::EMIT_CW;

  // Control state
  logic [TW-1:0]          gap_len_r, gap_len_nxt;
  rps_pkg::mode_e         mode_r, mode_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [MAX_ENTRIES-1:0] on_r, on_nxt;
  logic [MAX_ENTRIES-1:0] done_r, done_nxt;
  logic [TW-1:0]          elapsed_r, elapsed_nxt;
  logic [TW-1:0]          pause_left_r, pause_left_nxt;
  logic                   in_gap_r, in_gap_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   pend_any_r, pend_any_nxt;
  logic [EW-1:0]          emit_cnt_r, emit_cnt_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Payload
  rps_pkg::in_word_t      word_r, word_nxt;
  rps_pkg::out_word_t     pend_r, pend_nxt;
  rps_pkg::out_word_t     out_r, out_nxt;

  rps_pkg::entry_t        wr_entry, rd_entry;
  rps_pkg::out_word_t     pend_word;
  logic [AW-1:0]          idx_a;
  logic [TW:0]            off_time;
  logic                   cur_on, cur_done, turn_on, turn_off, ev_change;
  logic                   cap_full, out_free, pend_wr, load_ok;

  // Entry table
  assign wr_entry = '{itf:      word_r.target_interface,
                      pin:      word_r.pin_number,
                      offset:   word_r.on_offset,
                      duration: word_r.on_duration};

  rps_ram #(
    .WIDTH ($bits(rps_pkg::entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_a),
    .rd_data (rd_entry)
  );

  // Evaluation of the entry under the walk index
  assign idx_a     = idx_r[AW-1:0];
  assign off_time  = {1'b0, rd_entry.offset} + {1'b0, rd_entry.duration};
  assign cur_on    = on_r[idx_a];
  assign cur_done  = done_r[idx_a];
  assign turn_off  = cur_on && (off_time <= {1'b0, elapsed_r});
  assign turn_on   = !cur_on && (rd_entry.offset <= elapsed_r);
  assign ev_change = !cur_done && (turn_off || turn_on);

  assign load_ok = (mode_r == rps_pkg::MODE_IDLE) &&
                   (count_r < CW'(MAX_ENTRIES)) &&
                   (word_r.target_interface != rps_pkg::ITF_INVALID);

  // Result emission
  assign cap_full = (emit_cnt_r == EW'(rps_pkg::RESULT_CAP));
  assign out_free = !out_valid_r || out_ready;
  assign pend_wr  = !cap_full &&
                    (cmd.st_emit || cmd.report || (cmd.ev_commit && ev_change));

  always_comb begin
    pend_word = '0;
    if (cmd.report) begin
      pend_word.kind = rps_pkg::KIND_REPORT;
    end else begin
      pend_word.kind          = rps_pkg::KIND_LEVEL;
      pend_word.channel       = rps_pkg::CHAN_W'(idx_r);
      pend_word.out_interface = rd_entry.itf;
      pend_word.out_pin       = rd_entry.pin;
      pend_word.level         = cmd.st_emit ? 1'b0 : turn_on;
    end
  end

  // Next state of the sequencer
  always_comb begin
    gap_len_nxt    = cfg_we ? cfg_data : gap_len_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    on_nxt         = on_r;
    done_nxt       = done_r;
    elapsed_nxt    = elapsed_r;
    pause_left_nxt = pause_left_r;
    in_gap_nxt     = in_gap_r;
    idx_nxt        = idx_r;
    pend_any_nxt   = pend_any_r;
    emit_cnt_nxt   = emit_cnt_r;
    word_nxt       = word_r;

    if (cmd.latch) begin
      word_nxt     = in_data;
      emit_cnt_nxt = '0;
    end
    if (cmd.load) begin
      on_nxt[count_r[AW-1:0]]   = 1'b0;
      done_nxt[count_r[AW-1:0]] = 1'b0;
      count_nxt                 = count_r + CW'(1);
    end
    if (cmd.tick_gap && pause_left_r != '0) begin
      pause_left_nxt = pause_left_r - TW'(1);
    end
    if (cmd.tick_adv) begin
      if (elapsed_r != '1) elapsed_nxt = elapsed_r + TW'(1);
      idx_nxt      = '0;
      pend_any_nxt = 1'b0;
    end
    if (cmd.restart) begin
      on_nxt         = '0;
      done_nxt       = '0;
      elapsed_nxt    = '0;
      in_gap_nxt     = 1'b0;
      pause_left_nxt = '0;
      mode_nxt       = rps_pkg::MODE_RUN;
      idx_nxt        = '0;
      pend_any_nxt   = 1'b0;
    end
    if (cmd.pause) begin
      on_nxt         = '0;
      done_nxt       = '0;
      in_gap_nxt     = 1'b0;
      pause_left_nxt = '0;
      mode_nxt       = rps_pkg::MODE_PAUSE;
    end
    if (cmd.report || cmd.abort) begin
      count_nxt      = '0;
      on_nxt         = '0;
      done_nxt       = '0;
      in_gap_nxt     = 1'b0;
      pause_left_nxt = '0;
      elapsed_nxt    = '0;
      mode_nxt       = rps_pkg::MODE_IDLE;
    end
    if (cmd.idx_clr) idx_nxt = '0;
    if (cmd.st_emit) idx_nxt = idx_r + CW'(1);
    if (cmd.ev_commit) begin
      if (!cur_done) begin
        pend_any_nxt = 1'b1;
        if (turn_off) begin
          on_nxt[idx_a]   = 1'b0;
          done_nxt[idx_a] = 1'b1;
        end else if (turn_on) begin
          on_nxt[idx_a] = 1'b1;
        end
      end
      idx_nxt = idx_r + CW'(1);
    end
    if (cmd.ev_end && !pend_any_r) begin
      on_nxt         = '0;
      done_nxt       = '0;
      in_gap_nxt     = 1'b1;
      pause_left_nxt = (gap_len_r == '0) ? TW'(1) : gap_len_r;
    end
    if (pend_wr) emit_cnt_nxt = emit_cnt_r + EW'(1);
  end

  // Lookahead word and output register; the last word leaves only on flush
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    if (pend_wr) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = pend_word;
      pend_valid_nxt = 1'b1;
    end else if (cmd.flush && pend_valid_r && out_free) begin
      out_nxt        = pend_r;
      out_nxt.last   = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_len_r    <= '0;
      mode_r       <= rps_pkg::MODE_IDLE;
      count_r      <= '0;
      on_r         <= '0;
      done_r       <= '0;
      elapsed_r    <= '0;
      pause_left_r <= '0;
      in_gap_r     <= 1'b0;
      idx_r        <= '0;
      pend_any_r   <= 1'b0;
      emit_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      gap_len_r    <= gap_len_nxt;
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      on_r         <= on_nxt;
      done_r       <= done_nxt;
      elapsed_r    <= elapsed_nxt;
      pause_left_r <= pause_left_nxt;
      in_gap_r     <= in_gap_nxt;
      idx_r        <= idx_nxt;
      pend_any_r   <= pend_any_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Status to controller
  assign sts = '{mode:        mode_r,
                 cmd:         rps_pkg::cmd_e'(word_r.command),
                 load_ok:     load_ok,
                 in_gap:      in_gap_r,
                 gap_restart: in_gap_r && (pause_left_r <= TW'(1)),
                 idx_end:     (idx_r == count_r),
                 ev_change:   ev_change,
                 emit_go:     cap_full || !pend_valid_r || out_free,
                 pend_valid:  pend_valid_r,
                 out_free:    out_free};

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // A new lookahead word never overwrites a full output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_wr && pend_valid_r) |-> out_free)
    else $error("lookahead pushed into a busy output register");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  // The gap always has ticks left and only exists while running
  a_gap_sane: assert property (@(posedge clk) disable iff (!rst_n)
    in_gap_r |-> (pause_left_r != '0 && mode_r == rps_pkg::MODE_RUN))
    else $error("gap state inconsistent");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == rps_pkg::MODE_IDLE) |-> (elapsed_r == '0 && on_r == '0))
    else $error("idle with live timing state");

  a_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (on_r & done_r) == '0)
    else $error("entry both on and finished");

endmodule

`default_nettype wire

>>> hw/rtl/repeating_pulse_sequencer.sv
// Top level of the repeating pulse sequencer: controller plus datapath.
// Depends on rps_pkg, rps_if, rps_ctrl, rps_datapath (and rps_ram below it).
//
//   channel  dir  payload                                        handshake
//   in_ch    in   command, target_interface, pin_number,         valid/ready
//                 on_offset, on_duration
//   out_ch   out  kind, channel, out_interface, out_pin,         valid/ready
//                 level, last
//   cfg_ch   in   gap length between cycles (32 bits)            valid/ready
//
// Each word goes through decode and finish; a tick that is due a walk and a
// continue add a walk of the table, start first drives the entries low and then
// walks, and stop adds the report. The walk reads one entry at a time from the single RAM read port.
// A stalled out_ch holds the sequencer; one result waits in a lookahead word so that
// last can be set. Input is taken only between words; cfg_ch is always ready.
// Reset is synchronous, active low; the table needs no clearing pass.
`default_nettype none

module repeating_pulse_sequencer #(
  parameter int MAX_ENTRIES = rps_pkg::MAX_ENTRIES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rps_in_if.sink    in_ch,
  rps_out_if.source out_ch,
  rps_cfg_if.sink   cfg_ch
);

  rps_pkg::ctrl_cmd_t ctl_cmd;
  rps_pkg::ctrl_sts_t ctl_sts;
  logic               in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  rps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (ctl_cmd),
    .sts      (ctl_sts)
  );

  rps_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts),
    .in_data   (in_ch.data),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule

`default_nettype wire
